/* rtl/bpc_pkg.sv */
// Shared types and constants for the box plane cull block.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

    localparam int WORD_W  = 32;              // Q16.16 field width
    localparam int PLANE_W = 4 * WORD_W;      // nx, ny, nz, dist
    localparam int PROD_W  = 2 * WORD_W;      // full Q32.32 product
    localparam int DIST_W  = WORD_W + 16;     // dist scaled to Q16.32
    localparam int PART_W  = PROD_W + 1;      // sum of two terms
    localparam int SUM_W   = PROD_W + 2;      // sum of four terms
    localparam int CNT_W   = 6;               // plane count, 0..32

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_ADD      = 2'd1,
        CMD_CULL_UPD = 2'd2,
        CMD_CULL_TST = 2'd3
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the transaction fields
        logic exec;     // run clear or add
        logic issue;    // read one plane into the test pipeline
        logic commit;   // write back the inside flags when allowed
        logic resp;     // register the result
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op              op;
        logic             pipe_busy;
        logic [CNT_W-1:0] count;
    } t_dp_status;

endpackage
`default_nettype wire

/* rtl/bpc_ram.sv */
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bpc_ram #(
    parameter int WIDTH  = 128,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/bpc_ctrl.sv */
// Sequencing state machine for the box plane cull block.
`timescale 1ns / 1ps
`default_nettype none
module bpc_ctrl #(
    parameter int IDX_W = 5
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire bpc_pkg::t_dp_status   i_status,
    output bpc_pkg::t_dp_cmd           o_cmd,
    output logic [IDX_W-1:0]           o_rd_idx
);

    localparam int CW = bpc_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_WALK,
        ST_DRAIN,
        ST_COMMIT,
        ST_RESP
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             last_idx;

    assign last_idx = ((CW'(r_idx) + CW'(1)) == i_status.count);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DECODE;
                end
                n_idx = '0;
            end
            ST_DECODE: begin
                if (i_status.op == bpc_pkg::CMD_CLEAR || i_status.op == bpc_pkg::CMD_ADD) begin
                    n_state = ST_EXEC;
                end else if (i_status.count == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_state = ST_WALK;
                end
            end
            ST_EXEC: n_state = ST_RESP;
            ST_WALK: begin
                n_idx = r_idx + IDX_W'(1);
                if (last_idx) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: n_state = ST_RESP;
            ST_RESP:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_cmd.load    = (r_state == ST_IDLE) && i_start;
    assign o_cmd.exec    = (r_state == ST_EXEC);
    assign o_cmd.issue   = (r_state == ST_WALK);
    assign o_cmd.commit  = (r_state == ST_COMMIT);
    assign o_cmd.resp    = (r_state == ST_RESP);
    assign o_rd_idx      = r_idx;

    // The test pipeline is empty whenever no transaction is in flight.
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !i_status.pipe_busy)
        else $error("test pipeline busy while idle");

    // Only planes below the stored count are read.
    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (CW'(r_idx) < i_status.count))
        else $error("plane read beyond stored count");

    // One result per transaction, never two in a row.
    a_resp_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.resp |=> !o_cmd.resp && !o_cmd.commit)
        else $error("result issued twice");

endmodule
`default_nettype wire

/* rtl/bpc_dp.sv */
// Datapath: plane table, corner test pipeline, flags and result registers.
`timescale 1ns / 1ps
`default_nettype none
module bpc_dp #(
    parameter int MAX_PLANES = 32,
    parameter int IDX_W      = 5
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bpc_pkg::t_dp_cmd                i_cmd,
    input  wire logic [IDX_W-1:0]                i_rd_idx,
    output bpc_pkg::t_dp_status                  o_status,
    input  wire logic [1:0]                      i_op,
    input  wire logic signed [bpc_pkg::WORD_W-1:0] i_plane_nx,
    input  wire logic signed [bpc_pkg::WORD_W-1:0] i_plane_ny,
    input  wire logic signed [bpc_pkg::WORD_W-1:0] i_plane_nz,
    input  wire logic signed [bpc_pkg::WORD_W-1:0] i_plane_dist,
    input  wire logic signed [bpc_pkg::WORD_W-1:0] i_box_min_x,
    input  wire logic signed [bpc_pkg::WORD_W-1:0] i_box_min_y,
    input  wire logic signed [bpc_pkg::WORD_W-1:0] i_box_min_z,
    input  wire logic signed [bpc_pkg::WORD_W-1:0] i_box_max_x,
    input  wire logic signed [bpc_pkg::WORD_W-1:0] i_box_max_y,
    input  wire logic signed [bpc_pkg::WORD_W-1:0] i_box_max_z,
    output logic                                 o_valid,
    output logic                                 o_culled,
    output logic                                 o_fully_inside,
    output logic [bpc_pkg::CNT_W-1:0]            o_planes_stored,
    output logic                                 o_table_full_error
);

    localparam int W  = bpc_pkg::WORD_W;
    localparam int PW = bpc_pkg::PROD_W;
    localparam int DW = bpc_pkg::DIST_W;
    localparam int QW = bpc_pkg::PART_W;
    localparam int SW = bpc_pkg::SUM_W;
    localparam int CW = bpc_pkg::CNT_W;

    // Captured transaction
    bpc_pkg::t_op                 r_op;
    logic [bpc_pkg::PLANE_W-1:0]  r_plane;
    logic signed [W-1:0]          r_mnx, r_mny, r_mnz, r_mxx, r_mxy, r_mxz;

    // Architectural state
    logic [CW-1:0]                r_count;
    logic [MAX_PLANES-1:0]        r_mask;
    logic [MAX_PLANES-1:0]        r_flags;
    logic                         r_culled;
    logic                         r_err;

    // Pipeline
    logic                         r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]             r_i1, r_i2, r_i3;
    logic [bpc_pkg::PLANE_W-1:0]  rd_data;
    logic signed [PW-1:0]         r_pxl, r_pxh, r_pyl, r_pyh, r_pzl, r_pzh;
    logic signed [DW-1:0]         r_pd;
    logic signed [QW-1:0]         r_xy [4];
    logic signed [QW-1:0]         r_zd [2];

    // Result registers
    logic                         r_valid, r_res_culled, r_res_full, r_res_err;
    logic [CW-1:0]                r_res_count;

    logic                         full;
    logic                         add_we;
    logic signed [W-1:0]          rd_nx, rd_ny, rd_nz, rd_dist;
    logic                         all_in, none_in;
    logic signed [SW-1:0]         corner_sum [8];
    logic                         fully_in;

    assign full   = (r_count >= CW'(MAX_PLANES));
    assign add_we = i_cmd.exec && (r_op == bpc_pkg::CMD_ADD) && !full;

    bpc_ram #(
        .WIDTH  (bpc_pkg::PLANE_W),
        .DEPTH  (MAX_PLANES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (add_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (r_plane),
        .i_re    (i_cmd.issue),
        .i_raddr (i_rd_idx),
        .o_rdata (rd_data)
    );

    assign rd_nx   = rd_data[4*W-1:3*W];
    assign rd_ny   = rd_data[3*W-1:2*W];
    assign rd_nz   = rd_data[2*W-1:W];
    assign rd_dist = rd_data[W-1:0];

    // Final corner sums: x/y pair plus z/dist pair, inside when not negative.
    always_comb begin
        all_in  = 1'b1;
        none_in = 1'b1;
        for (int c = 0; c < 8; c++) begin
            corner_sum[c] = SW'(r_xy[c % 4]) + SW'(r_zd[c / 4]);
            if (corner_sum[c][SW-1]) begin
                all_in = 1'b0;
            end else begin
                none_in = 1'b0;
            end
        end
    end

    always_comb begin
        fully_in = 1'b1;
        for (int i = 0; i < MAX_PLANES; i++) begin
            if (r_mask[i] != (CW'(i) < r_count)) begin
                fully_in = 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= bpc_pkg::t_op'(i_op);
            r_plane <= {i_plane_nx, i_plane_ny, i_plane_nz, i_plane_dist};
            r_mnx   <= i_box_min_x;
            r_mny   <= i_box_min_y;
            r_mnz   <= i_box_min_z;
            r_mxx   <= i_box_max_x;
            r_mxy   <= i_box_max_y;
            r_mxz   <= i_box_max_z;
        end
        // products of each normal component with both box extents
        r_pxl <= rd_nx * r_mnx;
        r_pxh <= rd_nx * r_mxx;
        r_pyl <= rd_ny * r_mny;
        r_pyh <= rd_ny * r_mxy;
        r_pzl <= rd_nz * r_mnz;
        r_pzh <= rd_nz * r_mxz;
        r_pd  <= {rd_dist, 16'h0000};
        r_i1  <= i_rd_idx;
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_xy[0] <= QW'(r_pxh) + QW'(r_pyh);
        r_xy[1] <= QW'(r_pxl) + QW'(r_pyh);
        r_xy[2] <= QW'(r_pxh) + QW'(r_pyl);
        r_xy[3] <= QW'(r_pxl) + QW'(r_pyl);
        r_zd[0] <= QW'(r_pzh) - QW'(r_pd);
        r_zd[1] <= QW'(r_pzl) - QW'(r_pd);
        if (i_cmd.resp) begin
            r_res_culled <= r_culled;
            r_res_full   <= fully_in;
            r_res_count  <= r_count;
            r_res_err    <= r_err;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_mask   <= '0;
            r_flags  <= '0;
            r_culled <= 1'b0;
            r_err    <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_v1    <= i_cmd.issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_valid <= i_cmd.resp;
            if (i_cmd.load) begin
                r_culled <= 1'b0;
                r_err    <= 1'b0;
                r_flags  <= r_mask;
            end
            if (i_cmd.exec) begin
                if (r_op == bpc_pkg::CMD_CLEAR) begin
                    r_count <= '0;
                    r_mask  <= '0;
                end else if (full) begin
                    r_err <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            // skip planes already marked inside
            if (r_v3 && !r_mask[r_i3]) begin
                if (none_in) begin
                    r_culled <= 1'b1;
                end
                if (all_in) begin
                    r_flags[r_i3] <= 1'b1;
                end
            end
            if (i_cmd.commit && (r_op == bpc_pkg::CMD_CULL_UPD) && !r_culled) begin
                r_mask <= r_flags;
            end
        end
    end

    assign o_status.op        = r_op;
    assign o_status.pipe_busy = r_v1 | r_v2 | r_v3;
    assign o_status.count     = r_count;

    assign o_valid            = r_valid;
    assign o_culled           = r_res_culled;
    assign o_fully_inside     = r_res_full;
    assign o_planes_stored    = r_res_count;
    assign o_table_full_error = r_res_err;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PLANES))
        else $error("plane count above table depth");

    a_err_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res_err) |-> (r_res_count == CW'(MAX_PLANES)) && !r_res_culled)
        else $error("full error without a full table");

    a_mask_stable_on_cull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_culled) |=> $stable(r_mask))
        else $error("inside flags written for a culled box");

endmodule
`default_nettype wire

/* rtl/box_plane_cull_with_inside_flags_top.sv */
// Top level of the box plane cull block with sticky inside flags.
// Sequence: clear and add go from accept straight to execute and respond; a cull
//   walks the stored planes (one plane read per cycle from the plane RAM), then a
//   3-stage multiply and add pipeline drains; an empty table skips the walk.
// Throughput: one transaction at a time; a new one is accepted only when idle.
// The receiver cannot stall: o_valid is a one-cycle strobe.
// Reset (synchronous, active low) empties the plane table and clears all inside flags.
`timescale 1ns / 1ps
`default_nettype none
module box_plane_cull_with_inside_flags_top #(
    parameter int MAX_PLANES = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         i_cmd,
    input  wire logic signed [bpc_pkg::WORD_W-1:0]  i_plane_nx,
    input  wire logic signed [bpc_pkg::WORD_W-1:0]  i_plane_ny,
    input  wire logic signed [bpc_pkg::WORD_W-1:0]  i_plane_nz,
    input  wire logic signed [bpc_pkg::WORD_W-1:0]  i_plane_dist,
    input  wire logic signed [bpc_pkg::WORD_W-1:0]  i_box_min_x,
    input  wire logic signed [bpc_pkg::WORD_W-1:0]  i_box_min_y,
    input  wire logic signed [bpc_pkg::WORD_W-1:0]  i_box_min_z,
    input  wire logic signed [bpc_pkg::WORD_W-1:0]  i_box_max_x,
    input  wire logic signed [bpc_pkg::WORD_W-1:0]  i_box_max_y,
    input  wire logic signed [bpc_pkg::WORD_W-1:0]  i_box_max_z,
    output logic                                    o_valid,
    output logic                                    o_culled,
    output logic                                    o_fully_inside,
    output logic [bpc_pkg::CNT_W-1:0]               o_planes_stored,
    output logic                                    o_table_full_error
);

    // Plane index width; a single-entry table still gets a one-bit index.
    localparam int IDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

    bpc_pkg::t_dp_cmd    dp_cmd;
    bpc_pkg::t_dp_status dp_status;
    logic [IDX_W-1:0]    rd_idx;

    // Controller: accepts the transaction and runs clear or add, or for a cull walks
    // the stored planes in table order, drains the pipeline, commits and responds.
    bpc_ctrl #(
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_rd_idx (rd_idx)
    );

    // Datapath: plane RAM, per-plane corner test, flag accumulation.
    // A cull tests every stored plane; flagged planes are skipped and the
    // culled flag is the OR of "all corners outside" over the rest.
    bpc_dp #(
        .MAX_PLANES (MAX_PLANES),
        .IDX_W      (IDX_W)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .i_rd_idx           (rd_idx),
        .o_status           (dp_status),
        .i_op               (i_cmd),
        .i_plane_nx         (i_plane_nx),
        .i_plane_ny         (i_plane_ny),
        .i_plane_nz         (i_plane_nz),
        .i_plane_dist       (i_plane_dist),
        .i_box_min_x        (i_box_min_x),
        .i_box_min_y        (i_box_min_y),
        .i_box_min_z        (i_box_min_z),
        .i_box_max_x        (i_box_max_x),
        .i_box_max_y        (i_box_max_y),
        .i_box_max_z        (i_box_max_z),
        .o_valid            (o_valid),
        .o_culled           (o_culled),
        .o_fully_inside     (o_fully_inside),
        .o_planes_stored    (o_planes_stored),
        .o_table_full_error (o_table_full_error)
    );

endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the box plane cull block with sticky inside flags.
`timescale 1ns / 1ps
module testbench;
    import bpc_pkg::*;

    localparam int TABLE_DEPTH    = 32;        // plane table size of the block
    localparam int UNIT           = 65536;     // 1.0 in Q16.16
    localparam int ITEM_TARGET    = 1450;      // no new sequence starts once this many are accepted
    localparam int DRAIN_CYCLES   = 48;        // quiet wait at the end, longer than the longest cull
    localparam int WATCHDOG_LIMIT = 2000;      // quiet cycles before the run is declared hung
    localparam int IDLE_PCT [3]   = '{0, 80, 31};

    typedef logic signed [WORD_W-1:0] q16_t;

    localparam q16_t Q_MIN = q16_t'(32'h8000_0000);
    localparam q16_t Q_MAX = q16_t'(32'h7FFF_FFFF);

    typedef enum {GEO_ENCLOSE, GEO_LOOSE, GEO_WILD} geo_mode_t;
    typedef enum {BOX_NEAR, BOX_POINT, BOX_WILD} box_mode_t;

    // One command transaction: plane fields matter for add, box fields for culls.
    typedef struct {
        t_op  op;
        q16_t nx, ny, nz, pd;
        q16_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    } cull_txn_t;

    typedef struct {
        logic             culled;
        logic             fully_inside;
        logic [CNT_W-1:0] planes_stored;
        logic             table_full_error;
    } cull_res_t;

    // Scoreboard: keeps its own plane table and inside flags, predicts the
    // response of every accepted transaction and checks responses in order.
    class cull_scoreboard;
        q16_t        pl_nx [TABLE_DEPTH];
        q16_t        pl_ny [TABLE_DEPTH];
        q16_t        pl_nz [TABLE_DEPTH];
        q16_t        pl_pd [TABLE_DEPTH];
        int          plane_cnt;
        logic [31:0] inside_flags;
        cull_res_t   expected_q [$];
        int          mismatches;

        function new();
            plane_cnt    = 0;
            inside_flags = '0;
            mismatches   = 0;
        endfunction

        // Exact test n.p - d >= 0 on the full Q36.32 sum.
        static function bit corner_inside(input logic signed [67:0] nx, ny, nz, pd, x, y, z);
            logic signed [67:0] sum;
            sum = nx * x + ny * y + nz * z - pd * 68'sd65536;
            return !sum[67];
        endfunction

        static function logic [31:0] all_set(int n);
            return 32'((64'd1 << n) - 64'd1);
        endfunction

        function void note_input(cull_txn_t t);
            cull_res_t          r;
            logic [31:0]        walk;
            int                 nin;
            int                 i;
            int                 c;
            logic signed [67:0] cx, cy, cz;
            r = '{default: 0};
            case (t.op)
                CMD_CLEAR: begin
                    plane_cnt    = 0;
                    inside_flags = '0;
                end
                CMD_ADD: begin
                    if (plane_cnt >= TABLE_DEPTH) begin
                        r.table_full_error = 1'b1;
                    end else begin
                        pl_nx[plane_cnt] = t.nx;
                        pl_ny[plane_cnt] = t.ny;
                        pl_nz[plane_cnt] = t.nz;
                        pl_pd[plane_cnt] = t.pd;
                        plane_cnt++;
                    end
                end
                default: begin
                    walk = inside_flags;
                    for (i = 0; i < plane_cnt && !r.culled; i++) begin
                        if (!walk[i]) begin
                            nin = 0;
                            for (c = 0; c < 8; c++) begin
                                cx = c[0] ? t.lo_x : t.hi_x;
                                cy = c[1] ? t.lo_y : t.hi_y;
                                cz = c[2] ? t.lo_z : t.hi_z;
                                if (corner_inside(pl_nx[i], pl_ny[i], pl_nz[i], pl_pd[i],
                                                  cx, cy, cz))
                                    nin++;
                            end
                            if (nin == 8)
                                walk[i] = 1'b1;
                            else if (nin == 0)
                                r.culled = 1'b1;
                        end
                    end
                    if (!r.culled && t.op == CMD_CULL_UPD)
                        inside_flags = walk;
                end
            endcase
            r.fully_inside  = (inside_flags == all_set(plane_cnt));
            r.planes_stored = plane_cnt[CNT_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(cull_res_t got);
            cull_res_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                $error("response strobe with no transaction outstanding");
                return;
            end
            want = expected_q.pop_front();
            check_field("culled", want.culled, got.culled);
            check_field("fully_inside", want.fully_inside, got.fully_inside);
            check_field("planes_stored", want.planes_stored, got.planes_stored);
            check_field("table_full_error", want.table_full_error, got.table_full_error);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------
    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       i_cmd;
    q16_t             i_plane_nx, i_plane_ny, i_plane_nz, i_plane_dist;
    q16_t             i_box_min_x, i_box_min_y, i_box_min_z;
    q16_t             i_box_max_x, i_box_max_y, i_box_max_z;
    logic             o_valid;
    logic             o_culled;
    logic             o_fully_inside;
    logic [CNT_W-1:0] o_planes_stored;
    logic             o_table_full_error;

    cull_scoreboard scoreboard;
    int             sent         = 0;   // transactions accepted so far
    int             idle_pct     = 0;   // chance in percent that the sender pauses
    int             quiet_cycles = 0;

    box_plane_cull_with_inside_flags_top #(
        .MAX_PLANES (TABLE_DEPTH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cmd              (i_cmd),
        .i_plane_nx         (i_plane_nx),
        .i_plane_ny         (i_plane_ny),
        .i_plane_nz         (i_plane_nz),
        .i_plane_dist       (i_plane_dist),
        .i_box_min_x        (i_box_min_x),
        .i_box_min_y        (i_box_min_y),
        .i_box_min_z        (i_box_min_z),
        .i_box_max_x        (i_box_max_x),
        .i_box_max_y        (i_box_max_y),
        .i_box_max_z        (i_box_max_z),
        .o_valid            (o_valid),
        .o_culled           (o_culled),
        .o_fully_inside     (o_fully_inside),
        .o_planes_stored    (o_planes_stored),
        .o_table_full_error (o_table_full_error)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus generators
    // ------------------------------------------------------------------
    function automatic q16_t rand_word();
        return q16_t'($urandom);
    endfunction

    // Q16.16 value with a whole part in [lo, hi] and a random fraction.
    function automatic q16_t rand_units(int lo, int hi);
        int whole;
        whole = lo + int'($urandom_range(hi - lo));
        return q16_t'((whole <<< 16) + int'($urandom_range(UNIT - 1)));
    endfunction

    // Normal component in [-1.0, 1.0].
    function automatic q16_t rand_normal();
        return q16_t'(int'($urandom_range(2 * UNIT)) - UNIT);
    endfunction

    // Any command with every field random; unused fields stay random too.
    function automatic cull_txn_t make_noise();
        cull_txn_t t;
        t.op   = t_op'($urandom_range(3));
        t.nx   = rand_word();
        t.ny   = rand_word();
        t.nz   = rand_word();
        t.pd   = rand_word();
        t.lo_x = rand_word();
        t.lo_y = rand_word();
        t.lo_z = rand_word();
        t.hi_x = rand_word();
        t.hi_y = rand_word();
        t.hi_z = rand_word();
        return t;
    endfunction

    function automatic cull_txn_t clear_txn();
        cull_txn_t t;
        t    = make_noise();
        t.op = CMD_CLEAR;
        return t;
    endfunction

    function automatic cull_txn_t plane_txn(q16_t nx, q16_t ny, q16_t nz, q16_t pd);
        cull_txn_t t;
        t    = make_noise();
        t.op = CMD_ADD;
        t.nx = nx;
        t.ny = ny;
        t.nz = nz;
        t.pd = pd;
        return t;
    endfunction

    function automatic cull_txn_t box_txn(t_op op, q16_t lx, q16_t ly, q16_t lz,
                                          q16_t hx, q16_t hy, q16_t hz);
        cull_txn_t t;
        t      = make_noise();
        t.op   = op;
        t.lo_x = lx;
        t.lo_y = ly;
        t.lo_z = lz;
        t.hi_x = hx;
        t.hi_y = hy;
        t.hi_z = hz;
        return t;
    endfunction

    // Enclosing planes keep the origin inside, so boxes near it tend to get
    // marked; loose planes cut through the box cloud; wild ones are raw bits.
    function automatic cull_txn_t make_add(geo_mode_t m);
        if (m == GEO_WILD)
            return plane_txn(rand_word(), rand_word(), rand_word(), rand_word());
        if (m == GEO_ENCLOSE)
            return plane_txn(rand_normal(), rand_normal(), rand_normal(), rand_units(-200, -1));
        return plane_txn(rand_normal(), rand_normal(), rand_normal(), rand_units(-100, 100));
    endfunction

    function automatic void axis_span(box_mode_t m, output q16_t lo, output q16_t hi);
        q16_t mid, half, tmp;
        case (m)
            BOX_NEAR: begin
                mid  = rand_units(-60, 60);
                half = rand_units(0, 40);
                lo   = mid - half;
                hi   = mid + half;
                // now and then hand over min above max
                if ($urandom_range(9) == 0) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
            BOX_POINT: begin
                lo = $urandom_range(1) ? rand_units(-1, 0) : rand_word();
                hi = lo;
            end
            default: begin
                lo = rand_word();
                hi = rand_word();
            end
        endcase
    endfunction

    function automatic cull_txn_t make_cull(t_op op, box_mode_t m);
        cull_txn_t t;
        t    = make_noise();
        t.op = op;
        axis_span(m, t.lo_x, t.hi_x);
        axis_span(m, t.lo_y, t.hi_y);
        axis_span(m, t.lo_z, t.hi_z);
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Driver: optionally pause, present the transaction, hold it until the
    // block takes it, then record it with the scoreboard. start stays high
    // on exit so back-to-back transactions need no extra edge.
    // ------------------------------------------------------------------
    task automatic send_item(cull_txn_t t);
        int held;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            held = 0;
            do begin
                @(posedge i_clk);
                held++;
            end while (held < 60 && $urandom_range(99) < idle_pct);
        end
        i_cmd        <= t.op;
        i_plane_nx   <= t.nx;
        i_plane_ny   <= t.ny;
        i_plane_nz   <= t.nz;
        i_plane_dist <= t.pd;
        i_box_min_x  <= t.lo_x;
        i_box_min_y  <= t.lo_y;
        i_box_min_z  <= t.lo_z;
        i_box_max_x  <= t.hi_x;
        i_box_max_y  <= t.hi_y;
        i_box_max_z  <= t.hi_z;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        scoreboard.note_input(t);
        sent++;
    endtask

    // ------------------------------------------------------------------
    // Response monitor: the strobe cannot be held off, so sample it at
    // every edge and check against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            scoreboard.check_result(cull_res_t'{o_culled, o_fully_inside,
                                                o_planes_stored, o_table_full_error});
    end

    // Watchdog: count edges where neither a command nor a response moves.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        geo_mode_t geo;
        box_mode_t box;
        t_op       op;
        int        seq;
        int        n_add;
        int        n_cull;
        int        roll;

        scoreboard   = new();
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = CMD_CLEAR;
        i_plane_nx   = '0;
        i_plane_ny   = '0;
        i_plane_nz   = '0;
        i_plane_dist = '0;
        i_box_min_x  = '0;
        i_box_min_y  = '0;
        i_box_min_z  = '0;
        i_box_max_x  = '0;
        i_box_max_y  = '0;
        i_box_max_z  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, no idling.
        // Cull against an empty table: nothing to test, fully inside holds.
        send_item(box_txn(CMD_CULL_UPD, 0, 0, 0, 0, 0, 0));
        send_item(box_txn(CMD_CULL_TST, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_item(clear_txn());
        // Plane x >= 0, then mark it with a box on the positive side.
        send_item(plane_txn(UNIT, 0, 0, 0));
        send_item(box_txn(CMD_CULL_UPD, UNIT, -5 * UNIT, -5 * UNIT,
                          2 * UNIT, 5 * UNIT, 5 * UNIT));
        // Plane already marked: skipped, so a box behind it is not culled.
        send_item(box_txn(CMD_CULL_UPD, -2 * UNIT, -5 * UNIT, -5 * UNIT,
                          -UNIT, 5 * UNIT, 5 * UNIT));
        // Plane x <= 10.
        send_item(plane_txn(-UNIT, 0, 0, -10 * UNIT));
        // Box past it: culled, flags left alone for test and update alike.
        send_item(box_txn(CMD_CULL_TST, 20 * UNIT, 0, 0, 30 * UNIT, UNIT, UNIT));
        send_item(box_txn(CMD_CULL_UPD, 20 * UNIT, 0, 0, 30 * UNIT, UNIT, UNIT));
        // Box straddling it: neither culled nor marked.
        send_item(box_txn(CMD_CULL_UPD, 5 * UNIT, 0, 0, 15 * UNIT, UNIT, UNIT));
        // Box inside it: test only must not mark, update must.
        send_item(box_txn(CMD_CULL_TST, 2 * UNIT, 0, 0, 3 * UNIT, UNIT, UNIT));
        send_item(box_txn(CMD_CULL_UPD, 2 * UNIT, 0, 0, 3 * UNIT, UNIT, UNIT));
        send_item(clear_txn());
        // Extreme planes and boxes, including a degenerate plane and min above max.
        send_item(plane_txn(Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        send_item(plane_txn(Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        send_item(plane_txn(0, 0, 0, 0));
        send_item(box_txn(CMD_CULL_TST, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_item(box_txn(CMD_CULL_UPD, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_item(box_txn(CMD_CULL_UPD, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        send_item(box_txn(CMD_CULL_UPD, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_item(box_txn(CMD_CULL_UPD, 0, 0, 0, 0, 0, 0));
        send_item(clear_txn());

        // Random part: each sequence optionally clears, loads a plane set and
        // then culls a run of boxes against it. The first sequence fills the
        // table past its end so the full-table drop and 32-plane case show up.
        seq = 0;
        while (sent < ITEM_TARGET) begin
            idle_pct = IDLE_PCT[(seq / 6) % 3];

            roll = $urandom_range(99);
            geo  = (seq == 0 || roll < 50) ? GEO_ENCLOSE : (roll < 85) ? GEO_LOOSE : GEO_WILD;

            roll = $urandom_range(99);
            if (seq == 0)
                n_add = TABLE_DEPTH + 2;
            else if (roll < 70)
                n_add = 1 + $urandom_range(7);
            else if (roll < 90)
                n_add = 9 + $urandom_range(22);
            else
                n_add = TABLE_DEPTH + $urandom_range(2);

            if (seq == 0 || $urandom_range(99) < 80)
                send_item(clear_txn());
            repeat (n_add)
                send_item(make_add(geo));

            n_cull = 4 + $urandom_range(16);
            repeat (n_cull) begin
                // sprinkle in fully random commands to break up the sequence
                if ($urandom_range(99) < 6) begin
                    send_item(make_noise());
                end else begin
                    roll = $urandom_range(99);
                    box  = (roll < 65) ? BOX_NEAR : (roll < 80) ? BOX_POINT : BOX_WILD;
                    op   = ($urandom_range(99) < 60) ? CMD_CULL_UPD : CMD_CULL_TST;
                    send_item(make_cull(op, box));
                end
            end
            seq++;
        end

        // Drop start on the edge of the last hand-off, drain, then let the
        // longest cull latency pass to catch any stray strobe.
        start <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (scoreboard.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/bpc_pkg.sv
rtl/bpc_ram.sv
rtl/bpc_ctrl.sv
rtl/bpc_dp.sv
rtl/box_plane_cull_with_inside_flags_top.sv
dv/testbench.sv
